/* src/isit_pkg.sv */
// Shared types, constants and controller states for the image slot index table.
package isit_pkg;

  // Default number of slots in the table.
  localparam int SLOT_COUNT_DEF = 30;

  // Slot value that marks a deleted slot, and the order map's undefined marker.
  localparam logic [7:0] MARK_DELETED   = 8'hFF;
  localparam logic [7:0] MARK_UNDEFINED = 8'hFE;

  // Operation codes carried in the mode field.
  typedef enum logic [3:0] {
    MODE_SET        = 4'd0,
    MODE_READ_ORDER = 4'd1,
    MODE_FIND       = 4'd2,
    MODE_NEXT       = 4'd3,
    MODE_SHIFT      = 4'd4,
    MODE_CLOSE      = 4'd5,
    MODE_REBUILD    = 4'd6,
    MODE_FREE       = 4'd7,
    MODE_CLEAR      = 4'd8
  } mode_t;

  // One request.
  typedef struct packed {
    logic [3:0] mode;
    logic [7:0] slot_address;
    logic [7:0] slot_value;
    logic [7:0] query_index;
  } in_req_t;

  // One result.
  typedef struct packed {
    logic [7:0] answer;
    logic       bad_address;
    logic       table_changed;
    logic [7:0] visible_total;
    logic [7:0] sum_out;
    logic [7:0] xor_out;
  } out_res_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SET_RD,
    ST_SET_WR,
    ST_MAP_RD,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_GAP_WR,
    ST_REB_CLR,
    ST_REB_RD,
    ST_REB_EV,
    ST_FILL_CHK,
    ST_FILL_EV,
    ST_DONE
  } state_t;

  // Source of the slot memory read address.
  typedef enum logic [1:0] {
    RSEL_REQ,
    RSEL_SCAN,
    RSEL_FREE
  } rd_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    slot_rd;
    rd_sel_t rd_sel;
    logic    set_wr;
    logic    scan_ev;
    logic    gap_wr;
    logic    reb_clr;
    logic    reb_ev;
    logic    fill_skip;
    logic    fill_ev;
    logic    map_rd;
    logic    finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       bad;
    logic       scan_last;
    logic       outer_last;
    logic       fill_done;
    logic       map_j_vld;
    logic [3:0] mode;
  } sts_t;

endpackage

/* src/isit_ctrl.sv */
// Controller state machine that sequences the slot walks of each operation.
module isit_ctrl import isit_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [3:0] in_mode,
  input  sts_t       sts,
  output cmd_t       cmd,
  output logic       busy
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_mode)
            MODE_SET:        state_nxt = ST_SET_RD;
            MODE_READ_ORDER: state_nxt = ST_MAP_RD;
            MODE_FIND,
            MODE_NEXT,
            MODE_SHIFT,
            MODE_CLOSE,
            MODE_FREE,
            MODE_CLEAR:      state_nxt = ST_SCAN_RD;
            MODE_REBUILD:    state_nxt = ST_REB_CLR;
            default:         state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SET_RD: state_nxt = sts.bad ? ST_DONE : ST_SET_WR;
      ST_SET_WR: state_nxt = ST_DONE;
      ST_MAP_RD: state_nxt = ST_DONE;
      ST_SCAN_RD: state_nxt = ST_SCAN_EV;
      ST_SCAN_EV: begin
        if (!sts.scan_last) begin
          state_nxt = ST_SCAN_RD;
        end else if (sts.mode == MODE_CLOSE) begin
          state_nxt = ST_GAP_WR;
        end else if (sts.mode == MODE_CLEAR) begin
          state_nxt = ST_REB_CLR;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_GAP_WR: state_nxt = sts.outer_last ? ST_DONE : ST_SCAN_RD;
      ST_REB_CLR: state_nxt = ST_REB_RD;
      ST_REB_RD: state_nxt = ST_REB_EV;
      ST_REB_EV: state_nxt = sts.scan_last ? ST_FILL_CHK : ST_REB_RD;
      ST_FILL_CHK: begin
        if (sts.fill_done) begin
          state_nxt = ST_DONE;
        end else if (!sts.map_j_vld) begin
          state_nxt = ST_FILL_EV;
        end
      end
      ST_FILL_EV: state_nxt = ST_FILL_CHK;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RSEL_REQ;
    case (state_r)
      ST_IDLE:    cmd.load = start;
      ST_SET_RD:  cmd.slot_rd = !sts.bad;
      ST_SET_WR:  cmd.set_wr = 1'b1;
      ST_MAP_RD:  cmd.map_rd = 1'b1;
      ST_SCAN_RD: begin
        cmd.slot_rd = 1'b1;
        cmd.rd_sel  = RSEL_SCAN;
      end
      ST_SCAN_EV: cmd.scan_ev = 1'b1;
      ST_GAP_WR:  cmd.gap_wr = 1'b1;
      ST_REB_CLR: cmd.reb_clr = 1'b1;
      ST_REB_RD: begin
        cmd.slot_rd = 1'b1;
        cmd.rd_sel  = RSEL_SCAN;
      end
      ST_REB_EV:  cmd.reb_ev = 1'b1;
      ST_FILL_CHK: begin
        if (!sts.fill_done) begin
          if (sts.map_j_vld) begin
            cmd.fill_skip = 1'b1;
          end else begin
            cmd.slot_rd = 1'b1;
            cmd.rd_sel  = RSEL_FREE;
          end
        end
      end
      ST_FILL_EV: cmd.fill_ev = 1'b1;
      ST_DONE:    cmd.finish = 1'b1;
      default:    cmd.finish = 1'b0;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

/* src/isit_dp.sv */
// Datapath: slot and order memories, walk pointers, search trackers and checksums.
module isit_dp import isit_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  in_req_t  in_req,
  input  cmd_t     cmd,
  output sts_t     sts,
  output logic     out_valid,
  output out_res_t out_res
);

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam logic [7:0]    N8       = 8'(SLOT_COUNT);
  localparam logic [AW-1:0] LAST_A   = AW'(SLOT_COUNT - 1);
  localparam logic [CW-1:0] NC       = CW'(SLOT_COUNT);
  localparam logic [7:0]    SUM_INIT = 8'((SLOT_COUNT * 255) % 256);
  localparam logic [7:0]    XOR_INIT = (SLOT_COUNT % 2 == 1) ? 8'hFF : 8'h00;

  // Memories and their per-entry valid bits (an invalid entry reads as its reset value).
  logic [7:0]            slot_mem [SLOT_COUNT];
  logic [7:0]            map_mem  [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_vld_r;
  logic [SLOT_COUNT-1:0] map_vld_r;

  in_req_t       req_r;
  logic [AW-1:0] scan_r, outer_r;
  logic [CW-1:0] fill_j_r, fill_k_r, vis_r;
  logic          match_r, best_r, changed_r, bad_r;
  logic [AW-1:0] match_addr_r, best_addr_r;
  logic [7:0]    best_val_r, sum_r, xor_r;
  logic [7:0]    slot_q_r, map_q_r;
  logic          slot_qv_r, map_qv_r;
  out_res_t      out_r;
  logic          out_valid_r;

  logic [AW-1:0] rd_addr;
  logic [7:0]    slot_val;
  logic [7:0]    key, lo;
  logic          wr_req;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_old, wr_new;
  logic          wr_do;
  logic          map_wr;
  logic [AW-1:0] map_wr_addr;
  logic [7:0]    map_wr_val;
  logic [7:0]    answer;
  logic          q_in_range;

  assign slot_val   = slot_qv_r ? slot_q_r : MARK_DELETED;
  assign q_in_range = (req_r.query_index < N8);

  // Slot read address.
  always_comb begin
    case (cmd.rd_sel)
      RSEL_REQ:  rd_addr = req_r.slot_address[AW-1:0];
      RSEL_SCAN: rd_addr = scan_r;
      RSEL_FREE: rd_addr = fill_k_r[AW-1:0];
      default:   rd_addr = scan_r;
    endcase
  end

  // Search key for the exact match and lower bound for the next-higher search.
  always_comb begin
    key = req_r.query_index;
    lo  = req_r.query_index;
    if (req_r.mode == MODE_FREE) begin
      key = MARK_DELETED;
    end
    if (req_r.mode == MODE_CLOSE) begin
      key = 8'(outer_r);
      lo  = 8'(outer_r);
    end
  end

  // Slot write request; a write of an unchanged value is dropped.
  always_comb begin
    wr_req  = 1'b0;
    wr_addr = scan_r;
    wr_old  = slot_val;
    wr_new  = slot_val;
    if (cmd.set_wr) begin
      wr_req  = 1'b1;
      wr_addr = req_r.slot_address[AW-1:0];
      wr_new  = req_r.slot_value;
    end else if (cmd.scan_ev && req_r.mode == MODE_SHIFT) begin
      wr_req = (slot_val > req_r.query_index) && (slot_val < N8);
      wr_new = slot_val - 8'd1;
    end else if (cmd.scan_ev && req_r.mode == MODE_CLEAR) begin
      wr_req = 1'b1;
      wr_new = MARK_DELETED;
    end else if (cmd.gap_wr) begin
      wr_req  = !match_r && best_r;
      wr_addr = best_addr_r;
      wr_old  = best_val_r;
      wr_new  = 8'(outer_r);
    end
  end
  assign wr_do = wr_req && (wr_old != wr_new);

  // Order map write: placement during the rebuild walk, then free-slot fill.
  always_comb begin
    map_wr      = 1'b0;
    map_wr_addr = slot_val[AW-1:0];
    map_wr_val  = 8'(scan_r);
    if (cmd.reb_ev && slot_val < N8) begin
      map_wr = 1'b1;
    end else if (cmd.fill_ev && slot_val == MARK_DELETED) begin
      map_wr      = 1'b1;
      map_wr_addr = fill_j_r[AW-1:0];
      map_wr_val  = 8'(fill_k_r);
    end
  end

  // Memory ports.
  always_ff @(posedge clk) begin
    if (wr_do) begin
      slot_mem[wr_addr] <= wr_new;
    end
    if (cmd.slot_rd) begin
      slot_q_r  <= slot_mem[rd_addr];
      slot_qv_r <= slot_vld_r[rd_addr];
    end
    if (map_wr) begin
      map_mem[map_wr_addr] <= map_wr_val;
    end
    if (cmd.map_rd && q_in_range) begin
      map_q_r  <= map_mem[req_r.query_index[AW-1:0]];
      map_qv_r <= map_vld_r[req_r.query_index[AW-1:0]];
    end
  end

  // Valid bits, checksums and visible count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= '0;
      map_vld_r  <= '0;
      sum_r      <= SUM_INIT;
      xor_r      <= XOR_INIT;
      vis_r      <= '0;
    end else begin
      if (wr_do) begin
        slot_vld_r[wr_addr] <= 1'b1;
        sum_r <= sum_r + wr_new - wr_old;
        xor_r <= xor_r ^ wr_new ^ wr_old;
      end
      if (cmd.reb_clr) begin
        map_vld_r <= '0;
        vis_r     <= '0;
      end else if (map_wr) begin
        map_vld_r[map_wr_addr] <= 1'b1;
        if (cmd.reb_ev) begin
          vis_r <= vis_r + CW'(1);
        end
      end
    end
  end

  // Request capture, walk pointers and search trackers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r     <= in_req;
      bad_r     <= (in_req.mode == MODE_SET) && (in_req.slot_address >= N8);
      changed_r <= 1'b0;
      outer_r   <= '0;
    end else if (wr_do) begin
      changed_r <= 1'b1;
    end
    if (cmd.load || cmd.gap_wr || cmd.reb_clr) begin
      scan_r  <= '0;
      match_r <= 1'b0;
      best_r  <= 1'b0;
    end else if (cmd.scan_ev || cmd.reb_ev) begin
      scan_r <= scan_r + AW'(1);
      if (!match_r && slot_val == key) begin
        match_r      <= 1'b1;
        match_addr_r <= scan_r;
      end
      if (slot_val >= lo && slot_val < N8 && (!best_r || slot_val < best_val_r)) begin
        best_r      <= 1'b1;
        best_val_r  <= slot_val;
        best_addr_r <= scan_r;
      end
    end
    if (cmd.gap_wr) begin
      outer_r <= outer_r + AW'(1);
    end
    if (cmd.reb_clr) begin
      fill_j_r <= '0;
      fill_k_r <= '0;
    end else if (cmd.fill_skip) begin
      fill_j_r <= fill_j_r + CW'(1);
    end else if (cmd.fill_ev) begin
      fill_k_r <= fill_k_r + CW'(1);
      if (slot_val == MARK_DELETED) begin
        fill_j_r <= fill_j_r + CW'(1);
      end
    end
  end

  // Answer by operation.
  always_comb begin
    case (req_r.mode)
      MODE_READ_ORDER: begin
        if (!q_in_range) begin
          answer = N8;
        end else begin
          answer = map_qv_r ? map_q_r : MARK_UNDEFINED;
        end
      end
      MODE_FIND,
      MODE_FREE: answer = match_r ? 8'(match_addr_r) : N8;
      MODE_NEXT: answer = best_r ? 8'(best_addr_r) : N8;
      default:   answer = 8'd0;
    endcase
  end

  // Result register and strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
    if (cmd.finish) begin
      out_r.answer        <= answer;
      out_r.bad_address   <= bad_r;
      out_r.table_changed <= changed_r;
      out_r.visible_total <= 8'(vis_r);
      out_r.sum_out       <= sum_r;
      out_r.xor_out       <= xor_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  // Status to the controller.
  assign sts.bad        = bad_r;
  assign sts.scan_last  = (scan_r == LAST_A);
  assign sts.outer_last = (outer_r == LAST_A);
  assign sts.fill_done  = (fill_j_r == NC) || (fill_k_r == NC);
  assign sts.map_j_vld  = map_vld_r[fill_j_r[AW-1:0]];
  assign sts.mode       = req_r.mode;

endmodule

/* src/image_slot_index_table_unit.sv */
// Top level of the image slot index table: controller plus datapath.
//
//   channel  ports                      direction  meaning
//   request  start, busy, in_req        in         one operation on the table
//   result   out_valid, out_res         out        one result per request
//
// A request is taken when start is high and busy is low; its result appears in the
// cycle in which busy falls and stays for exactly one cycle. Each slot visit takes a
// read state and an evaluate state because the slot memory has a registered read
// port. Close gaps, a walk nested inside another walk, is the longest operation.
// Reset is synchronous and leaves every slot deleted and the order map undefined at
// once; the receiver cannot stall the result.
module image_slot_index_table_unit import isit_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_res_t out_res
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  isit_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_req.mode),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  // Tables, trackers and checksums.
  isit_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

/* bench/testbench.sv */
// Testbench for the image slot index table: directed and random requests against a predictor.
module testbench;
  import isit_pkg::*;

  localparam int NSLOT = SLOT_COUNT_DEF;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  in_req_t  in_req;
  logic     out_valid;
  out_res_t out_res;

  image_slot_index_table_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_res(out_res)
  );

  // Predictor state.
  logic [7:0] tbl [NSLOT];
  logic [7:0] omap [NSLOT];
  logic [7:0] sum_q, xor_q;
  logic [7:0] vis_q;

  in_req_t  pending_reqs[$];
  out_res_t expected_results[$];
  int       mismatch_count = 0;
  bit       all_sent = 0;
  bit       drain_hold = 0;
  int       quiet_lo, quiet_hi;
  int       sent_count = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100000000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic bit write_slot(int a, logic [7:0] v);
    logic [7:0] old;
    old = tbl[a];
    if (old == v) return 0;
    tbl[a] = v;
    sum_q = sum_q + v - old;
    xor_q = xor_q ^ v ^ old;
    return 1;
  endfunction

  function automatic int find_addr(int idx);
    for (int a = 0; a < NSLOT; a++) if (tbl[a] == idx) return a;
    return NSLOT;
  endfunction

  function automatic int find_next(int idx);
    for (int i = idx; i < NSLOT; i++) if (find_addr(i) < NSLOT) return find_addr(i);
    return NSLOT;
  endfunction

  function automatic void rebuild_map();
    int freed[$];
    vis_q = 8'd0;
    for (int i = 0; i < NSLOT; i++) omap[i] = MARK_UNDEFINED;
    for (int i = 0; i < NSLOT; i++) begin
      if (tbl[i] == MARK_DELETED) freed.push_back(i);
      else if (tbl[i] < NSLOT) begin
        omap[tbl[i]] = 8'(i);
        vis_q++;
      end
    end
    for (int i = 0; i < NSLOT; i++)
      if (omap[i] == MARK_UNDEFINED && freed.size() > 0) omap[i] = 8'(freed.pop_front());
  endfunction

  // Compute the result of one request and update the predicted table.
  function automatic out_res_t apply_request(in_req_t r);
    out_res_t res;
    int q;
    int a;
    res = '0;
    q = int'(r.query_index);
    case (r.mode)
      MODE_SET: begin
        if (r.slot_address >= NSLOT) res.bad_address = 1'b1;
        else res.table_changed = write_slot(int'(r.slot_address), r.slot_value);
      end
      MODE_READ_ORDER: res.answer = (q < NSLOT) ? omap[q] : 8'(NSLOT);
      MODE_FIND: res.answer = 8'(find_addr(q));
      MODE_NEXT: res.answer = 8'(find_next(q));
      MODE_SHIFT: begin
        for (int i = 0; i < NSLOT; i++)
          if (tbl[i] > q && tbl[i] < NSLOT)
            res.table_changed |= write_slot(i, tbl[i] - 8'd1);
      end
      MODE_CLOSE: begin
        for (int i = 0; i < NSLOT; i++)
          if (find_addr(i) >= NSLOT) begin
            a = find_next(i);
            if (a < NSLOT) res.table_changed |= write_slot(a, 8'(i));
          end
      end
      MODE_REBUILD: rebuild_map();
      MODE_FREE: res.answer = 8'(find_addr(int'(MARK_DELETED)));
      MODE_CLEAR: begin
        for (int i = 0; i < NSLOT; i++) res.table_changed |= write_slot(i, MARK_DELETED);
        rebuild_map();
      end
      default: ;
    endcase
    res.visible_total = vis_q;
    res.sum_out = sum_q;
    res.xor_out = xor_q;
    return res;
  endfunction

  function automatic in_req_t make_req(int m, int a, int v, int q);
    in_req_t r;
    r.mode = 4'(m);
    r.slot_address = 8'(a);
    r.slot_value = 8'(v);
    r.query_index = 8'(q);
    return r;
  endfunction

  // Mostly in-range values so that searches and gap closing find something.
  function automatic in_req_t random_req();
    int m;
    int v;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) m = MODE_SET;
    else if (pick < 95) m = $urandom_range(1, 8);
    else m = $urandom_range(9, 15);
    if (m == MODE_CLEAR && $urandom_range(0, 3) != 0) m = MODE_REBUILD;
    pick = $urandom_range(0, 9);
    v = (pick < 7) ? $urandom_range(0, NSLOT - 1) : (pick < 9 ? MARK_DELETED : $urandom);
    return make_req(m,
      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, NSLOT - 1), v,
      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, NSLOT + 1));
  endfunction

  // Fill the request queue: directed cases first, then random traffic.
  initial begin
    pending_reqs.push_back(make_req(MODE_READ_ORDER, 0, 0, 0));
    pending_reqs.push_back(make_req(MODE_FREE, 0, 0, 0));
    pending_reqs.push_back(make_req(MODE_SET, 0, 5, 0));
    pending_reqs.push_back(make_req(MODE_SET, 0, 5, 0));
    pending_reqs.push_back(make_req(MODE_SET, NSLOT - 1, 2, 0));
    pending_reqs.push_back(make_req(MODE_SET, NSLOT, 1, 0));
    pending_reqs.push_back(make_req(MODE_SET, 255, 255, 255));
    pending_reqs.push_back(make_req(MODE_SET, 3, 200, 0));
    pending_reqs.push_back(make_req(MODE_SET, 4, 5, 0));
    pending_reqs.push_back(make_req(MODE_REBUILD, 0, 0, 0));
    pending_reqs.push_back(make_req(MODE_READ_ORDER, 0, 0, 5));
    pending_reqs.push_back(make_req(MODE_READ_ORDER, 0, 0, NSLOT - 1));
    pending_reqs.push_back(make_req(MODE_READ_ORDER, 0, 0, 255));
    pending_reqs.push_back(make_req(MODE_FIND, 0, 0, 2));
    pending_reqs.push_back(make_req(MODE_FIND, 0, 0, 255));
    pending_reqs.push_back(make_req(MODE_NEXT, 0, 0, 3));
    pending_reqs.push_back(make_req(MODE_NEXT, 0, 0, 200));
    pending_reqs.push_back(make_req(MODE_SHIFT, 0, 0, 1));
    pending_reqs.push_back(make_req(MODE_CLOSE, 0, 0, 0));
    pending_reqs.push_back(make_req(MODE_FREE, 0, 0, 0));
    pending_reqs.push_back(make_req(4'd15, 0, 0, 0));
    pending_reqs.push_back(make_req(MODE_CLEAR, 0, 0, 0));
    pending_reqs.push_back(make_req(MODE_READ_ORDER, 0, 0, 0));
    for (int i = 0; i < 900; i++) pending_reqs.push_back(random_req());
  end

  // Stretch with no idling at all.
  initial begin
    quiet_lo = 200;
    quiet_hi = 350;
  end

  // Driver: one request at a time, random idle cycles, one pause to drain.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 0;
      in_req <= '0;
    end else if (start && !busy) begin
      expected_results.push_back(apply_request(in_req));
      sent_count <= sent_count + 1;
      start <= 0;
    end else if (!start) begin
      if (sent_count == 400 && !drain_hold) drain_hold <= 1;
      else if (drain_hold && expected_results.size() != 0) ;
      else if (pending_reqs.size() == 0) all_sent <= 1;
      else if ((sent_count >= quiet_lo && sent_count < quiet_hi) ||
               $urandom_range(0, 99) >= 37) begin
        in_req <= pending_reqs.pop_front();
        start <= 1;
        if (drain_hold) drain_hold <= 0;
      end
    end
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk) begin
    out_res_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %h", out_res);
      end else begin
        want = expected_results.pop_front();
        if (want !== out_res) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: expected ans=%0d bad=%0b chg=%0b vis=%0d sum=%h xor=%h,",
                      " got ans=%0d bad=%0b chg=%0b vis=%0d sum=%h xor=%h"},
              want.answer, want.bad_address, want.table_changed, want.visible_total,
              want.sum_out, want.xor_out, out_res.answer, out_res.bad_address,
              out_res.table_changed, out_res.visible_total, out_res.sum_out, out_res.xor_out);
        end
      end
    end
  end

  // Reset, then wait for the end of traffic.
  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      tbl[i] = MARK_DELETED;
      omap[i] = MARK_UNDEFINED;
    end
    sum_q = 8'(NSLOT * 255);
    xor_q = (NSLOT % 2) ? 8'hFF : 8'h00;
    vis_q = 8'd0;
    rst_n = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    wait (all_sent && expected_results.size() == 0);
    repeat (2000) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
